FILE: hw/rtl/pls_pkg.sv
// Shared constants, operation codes and cell control type for the positional list store.
package pls_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int POS_W           = 7;
    localparam int DATA_W          = 32;
    localparam int CNT_W           = 7;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos_idx;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/pls_if.sv
// Request and response channel interfaces of the positional list store.
interface pls_req_if
    import pls_pkg::*;
();
    logic              valid;
    logic              ready;
    t_mode             mode;
    logic [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value_in;

    modport source (output valid, output mode, output position, output value_in, input ready);
    modport sink   (input valid, input mode, input position, input value_in, output ready);
endinterface

interface pls_rsp_if
    import pls_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;

    modport source (output valid, output ok, output read_value, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input ok, input read_value, input entry_count,
                    input is_empty, output ready);
endinterface

FILE: hw/rtl/pls_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbors.
module pls_cell
    import pls_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  t_cell_ctrl             i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-1:0] i_prev,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_hit
);

    localparam logic [POS_W-1:0] L_IDX = POS_W'(IDX);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   w_hit;

    assign w_hit = (i_ctrl.pos_idx == L_IDX);

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (w_hit) begin
                n_val = i_value;
            end else if (L_IDX > i_ctrl.pos_idx) begin
                n_val = i_prev;
            end
        end else if (i_ctrl.rem) begin
            if (L_IDX >= i_ctrl.pos_idx) begin
                n_val = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_value = r_val;
    assign o_hit   = w_hit ? r_val : '0;

endmodule

FILE: hw/rtl/positional_list_store_unit.sv
// Each result is registered at its request transfer and presented in the cycle after it.
// Throughput: one request per cycle; a stalled result holds off new requests until it transfers.
// Insert and remove shift the cells from the given position upward in parallel at the request transfer.
// Reset clears the entry count and the result valid flag; cell contents are not cleared.
// Top level of the positional list store: control, entry count and the row of cells.
module positional_list_store_unit
    import pls_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pls_req_if.sink   i_req,
    pls_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic                   r_ok;
    logic                   n_ok;
    logic [DATA_W-1:0]      r_rd;
    logic [DATA_W-1:0]      n_rd;

    logic                   w_accept;
    logic [CNT_W-1:0]       w_count_ext;
    logic                   w_pos_nz;
    logic                   w_in_range;
    logic                   w_ins_ok;
    t_cell_ctrl             w_ctrl;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_rd;
    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_hit [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_count_ext = CNT_W'(r_count);
    assign w_pos_nz    = (i_req.position != '0);
    assign w_in_range  = w_pos_nz && (i_req.position <= w_count_ext);
    assign w_ins_ok    = w_pos_nz && (i_req.position <= w_count_ext + 7'd1)
                         && (r_count < CW'(CAPACITY));
    assign w_value     = VALUE_WIDTH'(i_req.value_in);

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_hit[k];
        end
    end

    always_comb begin
        n_count        = r_count;
        n_ok           = 1'b0;
        n_rd           = '0;
        w_ctrl.ins     = 1'b0;
        w_ctrl.rem     = 1'b0;
        w_ctrl.pos_idx = i_req.position - 7'd1;
        unique case (i_req.mode)
            MODE_READ: begin
                n_ok = w_in_range;
                if (w_in_range) begin
                    n_rd = DATA_W'(signed'(w_rd));
                end
            end
            MODE_INSERT: begin
                n_ok       = w_ins_ok;
                w_ctrl.ins = w_accept && w_ins_ok;
                if (w_ins_ok) begin
                    n_count = r_count + CW'(1);
                end
            end
            MODE_REMOVE: begin
                n_ok       = w_in_range;
                w_ctrl.rem = w_accept && w_in_range;
                if (w_in_range) begin
                    n_count = r_count - CW'(1);
                end
            end
            MODE_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_prev;
        logic [VALUE_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_val[g];
        end else begin : g_mid_next
            assign w_next = w_val[g+1];
        end

        pls_cell #(
            .IDX         (g),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_value (w_value),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_val[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok <= n_ok;
            r_rd <= n_rd;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_ok;
    assign o_rsp.read_value  = r_rd;
    assign o_rsp.entry_count = CNT_W'(r_count);
    assign o_rsp.is_empty    = (r_count == '0);

endmodule

FILE: hw/rtl/pls_checker.sv
// Port-level checks of the positional list store and their binding to the top level.
module pls_checker
    import pls_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input t_mode             i_req_mode,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic              i_rsp_ok,
    input logic [DATA_W-1:0] i_rsp_read_value,
    input logic [CNT_W-1:0]  i_rsp_entry_count,
    input logic              i_rsp_is_empty
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_entry_count)
            && $stable(i_rsp_ok) && $stable(i_rsp_read_value))
        else $error("Response changed while stalled.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_is_empty == (i_rsp_entry_count == '0)))
        else $error("Empty flag disagrees with entry count.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_entry_count <= CNT_W'(CAPACITY)))
        else $error("Entry count exceeds capacity.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ok |-> (i_rsp_read_value == '0))
        else $error("Rejected operation returned a nonzero value.");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_mode == MODE_CLEAR)
            |=> i_rsp_valid && i_rsp_ok && i_rsp_is_empty)
        else $error("Clear transfer did not yield an empty list.");

endmodule

bind positional_list_store_unit pls_checker #(
    .CAPACITY (CAPACITY)
) u_pls_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_mode        (i_req.mode),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_ok          (o_rsp.ok),
    .i_rsp_read_value  (o_rsp.read_value),
    .i_rsp_entry_count (o_rsp.entry_count),
    .i_rsp_is_empty    (o_rsp.is_empty)
);
